FILE: design/mds_pkg.sv
// Shared types, codes and constants of the MIPS decode stage.
package mds_pkg;

   localparam int WORD_W = 32;
   localparam int REG_W = 5;
   localparam int REG_COUNT = 32;
   localparam int IMM_W = 26;
   localparam int OPC_W = 6;

   localparam logic REQ_DECODE = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [OPC_W-1:0] OP_RTYPE = 6'd0;
   localparam logic [OPC_W-1:0] OP_J = 6'd2;
   localparam logic [OPC_W-1:0] OP_JAL = 6'd3;
   localparam logic [OPC_W-1:0] OP_BEQ = 6'd4;
   localparam logic [OPC_W-1:0] OP_BNE = 6'd5;
   localparam logic [OPC_W-1:0] OP_SLTI = 6'd10;
   localparam logic [OPC_W-1:0] OP_SLTIU = 6'd11;
   localparam logic [OPC_W-1:0] OP_ANDI = 6'd12;
   localparam logic [OPC_W-1:0] OP_ORI = 6'd13;
   localparam logic [OPC_W-1:0] OP_LUI = 6'd15;
   localparam logic [OPC_W-1:0] OP_LW = 6'd35;
   localparam logic [OPC_W-1:0] OP_SW = 6'd43;

   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_BEQ = 3'd1,
      ALU_BNE = 3'd2,
      ALU_SLT = 3'd3,
      ALU_AND = 3'd4,
      ALU_OR = 3'd5,
      ALU_LUI = 3'd6,
      ALU_RTYPE = 3'd7
   } alu_op_type;

   typedef struct packed {
      logic memtoreg;
      logic regwrite;
      logic jump;
      logic branch;
      logic memwrite;
      logic memread;
      logic regdst;
      logic alusrc;
   } ctrl_flags_type;

   typedef struct packed {
      ctrl_flags_type control_flags;
      alu_op_type alu_operation;
      logic [WORD_W-1:0] first_operand;
      logic [WORD_W-1:0] second_operand;
      logic [REG_W-1:0] source_number;
      logic [REG_W-1:0] target_number;
      logic [REG_W-1:0] dest_number;
      logic [IMM_W-1:0] immediate_out;
      logic [WORD_W-1:0] pc_out;
   } decode_result_type;

   typedef struct packed {
      logic en;
      logic [REG_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } rf_write_type;

   typedef struct packed {
      logic en;
      logic [REG_W-1:0] addr_a;
      logic [REG_W-1:0] addr_b;
   } rf_read_type;

endpackage

FILE: design/mds_if.sv
// Valid/ready channel interfaces for request and response items.
interface mds_req_if import mds_pkg::*; ();
   logic valid;
   logic ready;
   logic req_type;
   logic [WORD_W-1:0] instruction;
   logic [WORD_W-1:0] fetch_pc;
   logic [REG_W-1:0] write_index;
   logic [WORD_W-1:0] write_value;

   modport source (
      output valid, req_type, instruction, fetch_pc, write_index, write_value,
      input ready
   );
   modport sink (
      input valid, req_type, instruction, fetch_pc, write_index, write_value,
      output ready
   );
endinterface

interface mds_rsp_if import mds_pkg::*; ();
   logic valid;
   logic ready;
   logic [7:0] control_flags;
   logic [2:0] alu_operation;
   logic [WORD_W-1:0] first_operand;
   logic [WORD_W-1:0] second_operand;
   logic [REG_W-1:0] source_number;
   logic [REG_W-1:0] target_number;
   logic [REG_W-1:0] dest_number;
   logic [IMM_W-1:0] immediate_out;
   logic [WORD_W-1:0] pc_out;

   modport source (
      output valid, control_flags, alu_operation, first_operand, second_operand,
         source_number, target_number, dest_number, immediate_out, pc_out,
      input ready
   );
   modport sink (
      input valid, control_flags, alu_operation, first_operand, second_operand,
         source_number, target_number, dest_number, immediate_out, pc_out,
      output ready
   );
endinterface

FILE: design/mds_regfile.sv
// Register file: one write port, two registered read ports, per-entry valid bits.
module mds_regfile import mds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  rf_write_type        wr,
   input  rf_read_type         rd,
   output logic [WORD_W-1:0]   rd_data_a,
   output logic [WORD_W-1:0]   rd_data_b
);

   logic [WORD_W-1:0] regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [REG_COUNT-1:0] valid_in;
   logic [WORD_W-1:0] data_a_ff;
   logic [WORD_W-1:0] data_b_ff;
   logic hit_a_ff;
   logic hit_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         data_a_ff <= regs_ff[rd.addr_a];
         data_b_ff <= regs_ff[rd.addr_b];
         hit_a_ff <= valid_ff[rd.addr_a];
         hit_b_ff <= valid_ff[rd.addr_b];
      end
   end

   assign rd_data_a = hit_a_ff ? data_a_ff : '0;
   assign rd_data_b = hit_b_ff ? data_b_ff : '0;

endmodule

FILE: design/mds_decode.sv
// Instruction field split and control decode for one item.
module mds_decode import mds_pkg::*; (
   input  logic [WORD_W-1:0]   instruction,
   input  logic [WORD_W-1:0]   pc,
   input  logic [WORD_W-1:0]   reg_a_data,
   input  logic [WORD_W-1:0]   reg_b_data,
   output decode_result_type   result
);

   logic [OPC_W-1:0] op;
   logic [IMM_W-1:0] imm16;

   assign op = instruction[31:26];
   assign imm16 = {{(IMM_W-16){1'b0}}, instruction[15:0]};

   always_comb begin
      result = '0;
      result.pc_out = pc;
      if (instruction != '0) begin
         result.source_number = instruction[25:21];
         case (op) inside
            OP_RTYPE: begin
               result.control_flags.regdst = 1'b1;
               result.control_flags.regwrite = 1'b1;
               result.alu_operation = ALU_RTYPE;
               result.first_operand = reg_a_data;
               result.second_operand = reg_b_data;
               result.target_number = instruction[20:16];
               result.dest_number = instruction[15:11];
               result.immediate_out = {{(IMM_W-6){1'b0}}, instruction[5:0]};
            end
            OP_J, OP_JAL: begin
               result.control_flags.jump = 1'b1;
               result.immediate_out = instruction[IMM_W-1:0];
            end
            OP_BEQ, OP_BNE: begin
               result.control_flags.branch = 1'b1;
               result.alu_operation = (op == OP_BEQ) ? ALU_BEQ : ALU_BNE;
               result.first_operand = reg_a_data;
               result.second_operand = reg_b_data;
               result.target_number = instruction[20:16];
               result.immediate_out = imm16;
            end
            OP_SW: begin
               result.control_flags.alusrc = 1'b1;
               result.control_flags.memwrite = 1'b1;
               result.first_operand = reg_a_data;
               result.second_operand = reg_b_data;
               result.target_number = instruction[20:16];
               result.immediate_out = imm16;
            end
            OP_LW: begin
               result.control_flags.alusrc = 1'b1;
               result.control_flags.memread = 1'b1;
               result.control_flags.regwrite = 1'b1;
               result.control_flags.memtoreg = 1'b1;
               result.first_operand = reg_a_data;
               result.second_operand = reg_b_data;
               result.target_number = instruction[20:16];
               result.immediate_out = imm16;
            end
            default: begin
               result.control_flags.alusrc = 1'b1;
               result.control_flags.regwrite = 1'b1;
               result.first_operand = reg_a_data;
               result.target_number = instruction[20:16];
               result.immediate_out = imm16;
               case (op) inside
                  OP_SLTI, OP_SLTIU: result.alu_operation = ALU_SLT;
                  OP_ANDI: result.alu_operation = ALU_AND;
                  OP_ORI: result.alu_operation = ALU_OR;
                  OP_LUI: result.alu_operation = ALU_LUI;
                  default: result.alu_operation = ALU_ADD;
               endcase
            end
         endcase
      end
   end

endmodule

FILE: design/mips_decode_stage.sv
// Decode stage top level: register file read, decode and output register.
// Registers are read into the register file's read registers when an item is accepted, the
// result is decoded from them and loaded into the output register, from which it is offered.
// Throughput: one item per cycle, decode or register write, while the output takes results.
// Reset empties the pipeline and clears the register valid bits, so every
// register reads zero until written; there is no clearing pass.
module mips_decode_stage import mds_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   mds_req_if.sink        req_port,
   mds_rsp_if.source      rsp_port
);

   logic s1_valid_ff;
   logic s1_valid_in;
   logic [WORD_W-1:0] s1_instr_ff;
   logic [WORD_W-1:0] s1_pc_ff;
   logic s2_valid_ff;
   logic s2_valid_in;
   decode_result_type out_ff;
   decode_result_type dec_result;
   logic s1_advance;
   logic req_accept;
   logic decode_accept;
   rf_write_type rf_wr;
   rf_read_type rf_rd;
   logic [WORD_W-1:0] reg_a_data;
   logic [WORD_W-1:0] reg_b_data;

   assign s1_advance = !s2_valid_ff || rsp_port.ready;
   assign req_port.ready = !s1_valid_ff || s1_advance;
   assign req_accept = req_port.valid && req_port.ready;
   assign decode_accept = req_accept && (req_port.req_type == REQ_DECODE);

   assign rf_wr.en = req_accept && (req_port.req_type == REQ_WRITE)
                     && (req_port.write_index != '0);
   assign rf_wr.addr = req_port.write_index;
   assign rf_wr.data = req_port.write_value;
   assign rf_rd.en = decode_accept;
   assign rf_rd.addr_a = req_port.instruction[25:21];
   assign rf_rd.addr_b = req_port.instruction[20:16];

   mds_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .rd        (rf_rd),
      .rd_data_a (reg_a_data),
      .rd_data_b (reg_b_data)
   );

   mds_decode u_decode (
      .instruction (s1_instr_ff),
      .pc          (s1_pc_ff),
      .reg_a_data  (reg_a_data),
      .reg_b_data  (reg_b_data),
      .result      (dec_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (decode_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s1_advance ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_accept) begin
         s1_instr_ff <= req_port.instruction;
         s1_pc_ff <= req_port.fetch_pc;
      end
      if (s1_advance && s1_valid_ff) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_port.valid = s2_valid_ff;
   assign rsp_port.control_flags = out_ff.control_flags;
   assign rsp_port.alu_operation = out_ff.alu_operation;
   assign rsp_port.first_operand = out_ff.first_operand;
   assign rsp_port.second_operand = out_ff.second_operand;
   assign rsp_port.source_number = out_ff.source_number;
   assign rsp_port.target_number = out_ff.target_number;
   assign rsp_port.dest_number = out_ff.dest_number;
   assign rsp_port.immediate_out = out_ff.immediate_out;
   assign rsp_port.pc_out = out_ff.pc_out;

   a_decode_enters: assert property (@(posedge clock) disable iff (reset)
      decode_accept |=> s1_valid_ff)
      else $error("decode item lost on entry");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_port.req_type == REQ_WRITE) |=> !s1_valid_ff)
      else $error("write item produced a pipeline entry");

   a_jump_no_operands: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_ff.control_flags.jump) |->
         (out_ff.first_operand == '0 && out_ff.second_operand == '0
          && out_ff.target_number == '0))
      else $error("jump carries operands");

   a_null_word: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_ff.control_flags == '0) |->
         (out_ff.alu_operation == ALU_ADD && out_ff.immediate_out == '0
          && out_ff.source_number == '0))
      else $error("all-zero word decoded with fields set");

   a_dest_needs_regdst: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_ff.dest_number != '0) |-> out_ff.control_flags.regdst)
      else $error("destination number outside R-type");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the MIPS decode stage and its register file.
module tb;
   import mds_pkg::*;

   localparam logic [OPC_W-1:0] OPC_ADDI = 6'd8;
   localparam logic [OPC_W-1:0] OPC_ADDIU = 6'd9;
   localparam logic [OPC_W-1:0] OPC_LBU = 6'd36;
   localparam logic [OPC_W-1:0] OPC_SB = 6'd40;
   localparam logic [OPC_W-1:0] OPC_UNDEF = 6'h3F;

   localparam int STALL_NONE = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_PATTERN = 2;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_PAUSE = 8;
   localparam int REPORT_CAP = 20;

   logic clock;
   logic reset;

   mds_req_if req_ch ();
   mds_rsp_if rsp_ch ();

   mips_decode_stage dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_ch),
      .rsp_port(rsp_ch)
   );

   logic [WORD_W-1:0] model_regs [REG_COUNT];
   decode_result_type pending_results [$];

   int mismatch_count = 0;
   int results_checked = 0;
   int decodes_seen = 0;
   int writes_seen = 0;
   int idle_cycles = 0;

   int stall_mode = STALL_NONE;
   int hold_request = 0;
   int hold_left = 0;
   int pattern_phase = 0;
   bit gaps_enabled = 1'b0;
   int burst_left = 0;

   logic [OPC_W-1:0] opcode_table [16] = '{
      OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OPC_ADDI, OPC_ADDIU, OP_SLTI,
      OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW, OPC_LBU, OPC_SB
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic decode_result_type predict_decode(input logic [WORD_W-1:0] word,
                                                        input logic [WORD_W-1:0] pc);
      decode_result_type r;
      logic [OPC_W-1:0] opc;
      logic [REG_W-1:0] rs;
      logic [REG_W-1:0] rt;
      r = '0;
      r.pc_out = pc;
      if (word != '0) begin
         opc = word[31:26];
         rs = word[25:21];
         rt = word[20:16];
         r.source_number = rs;
         r.alu_operation = ALU_ADD;
         case (opc)
            OP_RTYPE: begin
               r.control_flags.regdst = 1'b1;
               r.control_flags.regwrite = 1'b1;
               r.alu_operation = ALU_RTYPE;
               r.first_operand = model_regs[rs];
               r.second_operand = model_regs[rt];
               r.target_number = rt;
               r.dest_number = word[15:11];
               r.immediate_out = IMM_W'(word[5:0]);
            end
            OP_J, OP_JAL: begin
               r.control_flags.jump = 1'b1;
               r.immediate_out = word[25:0];
            end
            OP_BEQ, OP_BNE: begin
               r.control_flags.branch = 1'b1;
               r.alu_operation = (opc == OP_BEQ) ? ALU_BEQ : ALU_BNE;
               r.first_operand = model_regs[rs];
               r.second_operand = model_regs[rt];
               r.target_number = rt;
               r.immediate_out = IMM_W'(word[15:0]);
            end
            OP_SW: begin
               r.control_flags.alusrc = 1'b1;
               r.control_flags.memwrite = 1'b1;
               r.first_operand = model_regs[rs];
               r.second_operand = model_regs[rt];
               r.target_number = rt;
               r.immediate_out = IMM_W'(word[15:0]);
            end
            OP_LW: begin
               r.control_flags.alusrc = 1'b1;
               r.control_flags.memread = 1'b1;
               r.control_flags.regwrite = 1'b1;
               r.control_flags.memtoreg = 1'b1;
               r.first_operand = model_regs[rs];
               r.second_operand = model_regs[rt];
               r.target_number = rt;
               r.immediate_out = IMM_W'(word[15:0]);
            end
            default: begin
               r.control_flags.alusrc = 1'b1;
               r.control_flags.regwrite = 1'b1;
               r.first_operand = model_regs[rs];
               r.target_number = rt;
               r.immediate_out = IMM_W'(word[15:0]);
               case (opc)
                  OP_SLTI, OP_SLTIU: r.alu_operation = ALU_SLT;
                  OP_ANDI: r.alu_operation = ALU_AND;
                  OP_ORI: r.alu_operation = ALU_OR;
                  OP_LUI: r.alu_operation = ALU_LUI;
                  default: r.alu_operation = ALU_ADD;
               endcase
            end
         endcase
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] encode_itype(input logic [OPC_W-1:0] opc,
                                                      input logic [REG_W-1:0] rs,
                                                      input logic [REG_W-1:0] rt,
                                                      input logic [15:0] imm);
      return {opc, rs, rt, imm};
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // check results and track accepted items
   always @(posedge clock) begin : monitor
      decode_result_type want;
      if (reset || !((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)))
         idle_cycles++;
      else
         idle_cycles = 0;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, pc_out", rsp_ch.pc_out, '0);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_ch.control_flags !== want.control_flags)
               report_mismatch("control_flags", WORD_W'(rsp_ch.control_flags),
                               WORD_W'(want.control_flags));
            if (rsp_ch.alu_operation !== want.alu_operation)
               report_mismatch("alu_operation", WORD_W'(rsp_ch.alu_operation),
                               WORD_W'(want.alu_operation));
            if (rsp_ch.first_operand !== want.first_operand)
               report_mismatch("first_operand", rsp_ch.first_operand, want.first_operand);
            if (rsp_ch.second_operand !== want.second_operand)
               report_mismatch("second_operand", rsp_ch.second_operand, want.second_operand);
            if (rsp_ch.source_number !== want.source_number)
               report_mismatch("source_number", WORD_W'(rsp_ch.source_number),
                               WORD_W'(want.source_number));
            if (rsp_ch.target_number !== want.target_number)
               report_mismatch("target_number", WORD_W'(rsp_ch.target_number),
                               WORD_W'(want.target_number));
            if (rsp_ch.dest_number !== want.dest_number)
               report_mismatch("dest_number", WORD_W'(rsp_ch.dest_number),
                               WORD_W'(want.dest_number));
            if (rsp_ch.immediate_out !== want.immediate_out)
               report_mismatch("immediate_out", WORD_W'(rsp_ch.immediate_out),
                               WORD_W'(want.immediate_out));
            if (rsp_ch.pc_out !== want.pc_out)
               report_mismatch("pc_out", rsp_ch.pc_out, want.pc_out);
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (req_ch.req_type == REQ_WRITE) begin
            writes_seen++;
            if (req_ch.write_index != '0)
               model_regs[req_ch.write_index] = req_ch.write_value;
         end else begin
            decodes_seen++;
            pending_results.push_back(predict_decode(req_ch.instruction, req_ch.fetch_pc));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE: rsp_ch.ready <= 1'b1;
            STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               pattern_phase = (pattern_phase + 1) % 7;
               rsp_ch.ready <= (pattern_phase > 2);
            end
         endcase
      end
   end

   task automatic send_item(input logic kind, input logic [WORD_W-1:0] word,
                            input logic [WORD_W-1:0] pc, input logic [REG_W-1:0] idx,
                            input logic [WORD_W-1:0] val);
      int gap;
      if (gaps_enabled && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      req_ch.req_type <= kind;
      req_ch.instruction <= word;
      req_ch.fetch_pc <= pc;
      req_ch.write_index <= idx;
      req_ch.write_value <= val;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic send_random_item();
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] val;
      int pick;
      pick = $urandom_range(0, 99);
      word = $urandom;
      val = $urandom;
      if (pick < 4)
         val = (pick < 2) ? '0 : '1;
      if (pick < 25) begin
         send_item(REQ_WRITE, word, $urandom, REG_W'($urandom_range(0, 31)), val);
      end else begin
         if (pick < 28)
            word = '0;
         else if (pick < 85)
            word[31:26] = opcode_table[$urandom_range(0, 15)];
         send_item(REQ_DECODE, word, $urandom, REG_W'($urandom_range(0, 31)), val);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic test_directed_decode();
      gaps_enabled = 1'b1;
      stall_mode = STALL_RANDOM;
      send_item(REQ_DECODE, '0, '1, 5'd31, '1);
      send_item(REQ_DECODE, {OP_RTYPE, 5'd31, 5'd31, 5'd31, 5'd31, 6'h3F}, '0, '0, '0);
      send_item(REQ_DECODE, {OP_J, 26'h3FFFFFF}, 32'h0040_0000, '0, '0);
      send_item(REQ_DECODE, {OP_JAL, 26'h2AAAAAA}, 32'h8000_0004, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_BEQ, 5'd1, 5'd2, 16'hFFFF), 32'h10, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_BNE, 5'd31, 5'd0, 16'h8000), 32'h14, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_SW, 5'd3, 5'd4, 16'h0000), 32'h18, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_LW, 5'd5, 5'd31, 16'h1234), 32'h1C, '0, '0);
      send_item(REQ_DECODE, encode_itype(OPC_ADDI, 5'd6, 5'd7, 16'h7FFF), 32'h20, '0, '0);
      send_item(REQ_DECODE, encode_itype(OPC_ADDIU, 5'd8, 5'd9, 16'h0001), 32'h24, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_SLTI, 5'd10, 5'd11, 16'hABCD), 32'h28, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_SLTIU, 5'd12, 5'd13, 16'h5432), 32'h2C, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_ANDI, 5'd14, 5'd15, 16'h00FF), 32'h30, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_ORI, 5'd16, 5'd17, 16'hFF00), 32'h34, '0, '0);
      send_item(REQ_DECODE, encode_itype(OP_LUI, 5'd0, 5'd18, 16'hDEAD), 32'h38, '0, '0);
      send_item(REQ_DECODE, encode_itype(OPC_LBU, 5'd19, 5'd20, 16'h0004), 32'h3C, '0, '0);
      send_item(REQ_DECODE, encode_itype(OPC_UNDEF, 5'd31, 5'd31, 16'hFFFF), 32'h40, '0, '0);
      wait_drained();
   endtask

   task automatic test_register_writes();
      gaps_enabled = 1'b0;
      stall_mode = STALL_PATTERN;
      send_item(REQ_WRITE, '1, '0, 5'd31, '1);
      send_item(REQ_WRITE, '0, '0, 5'd0, '1);
      send_item(REQ_DECODE, {OP_RTYPE, 5'd0, 5'd31, 5'd2, 5'd0, 6'h20}, 32'h100, '0, '0);
      send_item(REQ_WRITE, '0, '0, 5'd1, 32'hA5A5_A5A5);
      send_item(REQ_DECODE, encode_itype(OP_SW, 5'd1, 5'd1, 16'h0008), 32'h104, '0, '0);
      send_item(REQ_WRITE, '0, '0, 5'd1, 32'h5A5A_5A5A);
      send_item(REQ_DECODE, encode_itype(OP_BEQ, 5'd31, 5'd1, 16'hFFFE), 32'h108, '0, '0);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input int stall, input bit gaps);
      gaps_enabled = gaps;
      stall_mode = stall;
      repeat (count) send_random_item();
      wait_drained();
   endtask

   task automatic test_held_output();
      gaps_enabled = 1'b0;
      stall_mode = STALL_NONE;
      hold_request = 300;
      repeat (120) send_random_item();
      wait_drained();
   endtask

   initial begin
      foreach (model_regs[i])
         model_regs[i] = '0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_DECODE;
      req_ch.instruction <= '0;
      req_ch.fetch_pc <= '0;
      req_ch.write_index <= '0;
      req_ch.write_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_decode();
      test_register_writes();
      test_random_traffic(400, STALL_NONE, 1'b0);
      test_random_traffic(400, STALL_RANDOM, 1'b1);
      test_random_traffic(400, STALL_PATTERN, 1'b1);
      test_held_output();
      test_random_traffic(300, STALL_RANDOM, 1'b0);

      $display("Ran %0d decodes and %0d register writes, %0d results compared field by field,",
               decodes_seen, writes_seen, results_checked);
      $display("under bursty input, stalled and long held-off output, %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
design/mds_pkg.sv
design/mds_if.sv
design/mds_regfile.sv
design/mds_decode.sv
design/mips_decode_stage.sv
dv/tb.sv
